@@ rtl/core/smcd_pkg.sv @@
`timescale 1ns / 1ps
// shared codes, limits and helper function for the serial motion command decoder
// no dependencies
package smcd_pkg;

  // result action codes
  localparam logic [2:0] ACT_STOP   = 3'd0;
  localparam logic [2:0] ACT_TURN   = 3'd1;
  localparam logic [2:0] ACT_FMT    = 3'd2;
  localparam logic [2:0] ACT_SENSOR = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_ZERO   = 3'd5;
  localparam logic [2:0] ACT_BUSY   = 3'd6;
  localparam logic [2:0] ACT_MOTION = 3'd7;

  // motion base codes, arc side is added on top
  localparam logic [2:0] MOT_FWD   = 3'd0;
  localparam logic [2:0] MOT_BACK  = 3'd3;
  localparam logic [2:0] MOT_PIV_L = 3'd6;
  localparam logic [2:0] MOT_PIV_R = 3'd7;

  // register indexes
  localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
  localparam logic [1:0] REG_TURN_RPM    = 2'd1;
  localparam logic [1:0] REG_START_SPEED = 2'd2;
  localparam logic [1:0] REG_START_INNER = 2'd3;

  // register reset values and limits
  localparam logic [9:0]  MAX_SPEED_RST   = 10'd1000;
  localparam logic [9:0]  TURN_RPM_RST    = 10'd100;
  localparam logic [9:0]  START_SPEED_RST = 10'd200;
  localparam logic [6:0]  START_INNER_RST = 7'd50;
  localparam logic [6:0]  PCT_LIMIT       = 7'd100;
  localparam logic [8:0]  DEG_LIMIT       = 9'd360;
  localparam logic [11:0] TENTHS_LIMIT    = 12'd3600;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_L  = 8'h4c;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Y  = 8'h59;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // arc side
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_L    = 2'd1;
  localparam logic [1:0] SIDE_R    = 2'd2;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      r = c - CASE_OFS;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/smcd_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module smcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/serial_motion_command_decoder.sv @@
`timescale 1ns / 1ps
// serial motion command decoder top level: line store, character parser, registers
// depends on smcd_pkg and smcd_ram
//
// usage
//   input channel: one received character word per accept (in_valid_i high,
//   in_stall_o low), with the sensor_ready and turn_active flags sampled with
//   the terminator. ordinary characters go into the line ram at one word a
//   cycle while in_stall_o is low. a cr or lf ending a non-empty line starts
//   the decode: the parser streams the line back out of the ram one character
//   a cycle, and in_stall_o stays high throughout the decode.
//   output channel: at most one result word per terminator, held in an output
//   register until taken (out_valid_o high, out_stall_i low). collection of
//   the next line carries on while a result waits; only a decode finishing
//   with the output register still full waits for it to drain.
//   apb port: four registers at byte addresses 0, 4, 8 and 12, to be written only
//   while the block is idle, which the block itself does not enforce; writing
//   start speed or start percent also loads the held default.
//   reset: line empty, registers at their reset values, no result pending;
//   the line ram needs no clearing since only written entries are read.
module serial_motion_command_decoder #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        sensor_ready_i,
  input  logic        turn_active_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [2:0]  motion_o,
  output logic [9:0]  speed_rpm_o,
  output logic [6:0]  inner_percent_o,
  output logic        turn_left_o,
  output logic [11:0] angle_tenths_o,
  output logic [9:0]  turn_max_rpm_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(LINE_BYTES);

  // top level phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PRIME = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;
  localparam logic [1:0] PH_EMIT  = 2'd3;

  // parser states; each step of the parser consumes one character
  localparam logic [3:0] P_LEAD   = 4'd0;
  localparam logic [3:0] P_SIDE   = 4'd1;
  localparam logic [3:0] P_TA_BL  = 4'd2;
  localparam logic [3:0] P_TA_NUM = 4'd3;
  localparam logic [3:0] P_TA_FR  = 4'd4;
  localparam logic [3:0] P_TA_END = 4'd5;
  localparam logic [3:0] P_TR_BL  = 4'd6;
  localparam logic [3:0] P_TR_NUM = 4'd7;
  localparam logic [3:0] P_TR_TL  = 4'd8;
  localparam logic [3:0] P_Y_BL   = 4'd9;
  localparam logic [3:0] P_Y_Z    = 4'd10;
  localparam logic [3:0] P_MSP    = 4'd11;
  localparam logic [3:0] P_MSN    = 4'd12;
  localparam logic [3:0] P_MPB    = 4'd13;
  localparam logic [3:0] P_MPN    = 4'd14;
  localparam logic [3:0] P_MTAIL  = 4'd15;

  // command letters
  localparam logic [2:0] CMD_F = 3'd0;
  localparam logic [2:0] CMD_B = 3'd1;
  localparam logic [2:0] CMD_T = 3'd2;
  localparam logic [2:0] CMD_Y = 3'd3;
  localparam logic [2:0] CMD_L = 3'd4;
  localparam logic [2:0] CMD_R = 3'd5;

  // configuration registers
  logic [9:0] max_spd_q, turn_rpm_q, start_spd_q;
  logic [6:0] start_inr_q;
  logic [9:0] held_spd_q;
  logic [6:0] held_inr_q;

  // line collection
  logic [AW-1:0] cnt_q, len_q, idx_q, idx_d;
  logic          in_acc, is_term, ram_we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  // parser state
  logic [1:0]  ph_q, ph_d;
  logic [3:0]  pst_q, pst_d, eff;
  logic [2:0]  cmd_q, cmd_d;
  logic [1:0]  side_q, side_d;
  logic [9:0]  acc_q, acc_d;
  logic [11:0] ang_q, ang_d;
  logic [9:0]  spd_q, spd_d, trpm_q, trpm_d;
  logic [6:0]  inr_q, inr_d;
  logic        pct_q, pct_d, sens_q, busy_q;
  logic [2:0]  res_act_q, res_act_d, res_mot_q, res_mot_d;

  // character decode
  logic [7:0]  c, uc;
  logic        c_end, c_blank, c_digit, c_side;
  logic [3:0]  dig;
  logic [13:0] acc10, nx10;
  logic [11:0] tenths;
  logic        fin, emit, mfin, mok;
  logic        out_free, cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_stall_o = (ph_q != PH_IDLE);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign is_term = (rx_byte_i == smcd_pkg::CH_CR) || (rx_byte_i == smcd_pkg::CH_LF);
  assign ram_we  = in_acc && !is_term && (cnt_q < AW'(LINE_BYTES - 1));
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    case (paddr[3:2])
      smcd_pkg::REG_MAX_SPEED:   prdata = {22'd0, max_spd_q};
      smcd_pkg::REG_TURN_RPM:    prdata = {22'd0, turn_rpm_q};
      smcd_pkg::REG_START_SPEED: prdata = {22'd0, start_spd_q};
      default:                   prdata = {25'd0, start_inr_q};
    endcase
  end

  // line store: written while collecting, streamed out while decoding; input is
  // stalled during the decode so reads and writes never overlap
  assign raddr = (ph_q == PH_RUN) ? idx_q + AW'(1) : '0;

  smcd_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (rx_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // current character, zero past the end of the line
  assign c       = (idx_q < len_q) ? rdata : 8'h00;
  assign uc      = smcd_pkg::upcase(c);
  assign c_end   = (c == 8'h00);
  assign c_blank = (c == smcd_pkg::CH_SP) || (c == smcd_pkg::CH_TAB);
  assign c_digit = (c >= smcd_pkg::CH_ZERO) && (c <= smcd_pkg::CH_NINE);
  assign c_side  = (uc == smcd_pkg::CH_UP_L) || (uc == smcd_pkg::CH_UP_R);
  assign dig     = c[3:0];
  assign acc10   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign nx10    = acc10 + {10'd0, dig};
  // angle ends either straight after the whole number or after the tenths digit
  assign tenths  = (pst_q == P_TA_NUM) ? acc10[11:0] : ang_q;

  always_comb begin
    ph_d      = ph_q;
    pst_d     = pst_q;
    cmd_d     = cmd_q;
    side_d    = side_q;
    acc_d     = acc_q;
    ang_d     = ang_q;
    spd_d     = spd_q;
    inr_d     = inr_q;
    trpm_d    = trpm_q;
    pct_d     = pct_q;
    idx_d     = idx_q;
    res_act_d = res_act_q;
    res_mot_d = res_mot_q;
    fin       = 1'b0;
    emit      = 1'b0;
    mfin      = 1'b0;
    mok       = 1'b0;

    // a character that is not consumed by a state falls through to the next one
    eff = pst_q;
    if (pst_q == P_SIDE && !c_side && cmd_q != CMD_T) begin
      eff = P_MSP;
    end
    if (pst_q == P_TA_NUM && !c_digit && c != smcd_pkg::CH_DOT) begin
      eff = P_TA_END;
    end

    case (ph_q)
      PH_IDLE: begin
        if (in_acc && is_term && cnt_q != '0) begin
          ph_d   = PH_PRIME;
          pst_d  = P_LEAD;
          side_d = smcd_pkg::SIDE_NONE;
          spd_d  = held_spd_q;
          inr_d  = held_inr_q;
          pct_d  = 1'b0;
          idx_d  = '0;
        end
      end
      PH_PRIME: begin
        ph_d = PH_RUN;
      end
      PH_RUN: begin
        idx_d = idx_q + AW'(1);
        case (eff)
          P_LEAD: begin
            if (!c_blank) begin
              case (uc)
                smcd_pkg::CH_UP_X: begin
                  fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_STOP;
                end
                smcd_pkg::CH_UP_F: begin cmd_d = CMD_F; pst_d = P_SIDE; end
                smcd_pkg::CH_UP_B: begin cmd_d = CMD_B; pst_d = P_SIDE; end
                smcd_pkg::CH_UP_T: begin cmd_d = CMD_T; pst_d = P_SIDE; end
                smcd_pkg::CH_UP_Y: begin cmd_d = CMD_Y; pst_d = P_Y_BL; end
                smcd_pkg::CH_UP_L: begin cmd_d = CMD_L; pst_d = P_MSP; end
                smcd_pkg::CH_UP_R: begin cmd_d = CMD_R; pst_d = P_MSP; end
                default: fin = 1'b1;
              endcase
            end
          end
          P_SIDE: begin
            // only reached with an arc letter, or for a turn without one
            if (c_side) begin
              side_d = (uc == smcd_pkg::CH_UP_L) ? smcd_pkg::SIDE_L : smcd_pkg::SIDE_R;
              pst_d  = (cmd_q == CMD_T) ? P_TA_BL : P_MSP;
            end else begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
            end
          end
          P_TA_BL: begin
            if (c_digit) begin
              acc_d = {6'd0, dig};
              pst_d = P_TA_NUM;
            end else if (!c_blank) begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
            end
          end
          P_TA_NUM: begin
            // digit or dot here, anything else went to the angle end
            if (c_digit) begin
              if (nx10 > {5'd0, smcd_pkg::DEG_LIMIT}) begin
                fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
              end else begin
                acc_d = nx10[9:0];
              end
            end else begin
              pst_d = P_TA_FR;
            end
          end
          P_TA_FR: begin
            if (c_digit) begin
              ang_d = nx10[11:0];
              pst_d = P_TA_END;
            end else begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
            end
          end
          P_TA_END: begin
            if ((!c_end && !c_blank) || tenths == 12'd0 ||
                tenths > smcd_pkg::TENTHS_LIMIT) begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
            end else begin
              ang_d  = tenths;
              trpm_d = turn_rpm_q;
              if (c_end) begin
                fin = 1'b1; emit = 1'b1;
                res_act_d = sens_q ? smcd_pkg::ACT_TURN : smcd_pkg::ACT_SENSOR;
              end else begin
                pst_d = P_TR_BL;
              end
            end
          end
          P_TR_BL: begin
            if (c_end) begin
              fin = 1'b1; emit = 1'b1;
              res_act_d = sens_q ? smcd_pkg::ACT_TURN : smcd_pkg::ACT_SENSOR;
            end else if (c_digit && {6'd0, dig} <= max_spd_q) begin
              acc_d = {6'd0, dig};
              pst_d = P_TR_NUM;
            end else if (!c_blank) begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
            end
          end
          P_TR_NUM: begin
            if (c_digit) begin
              if (nx10 > {4'd0, max_spd_q}) begin
                fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
              end else begin
                acc_d = nx10[9:0];
              end
            end else if (acc_q == 10'd0 || (!c_end && !c_blank)) begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
            end else begin
              trpm_d = acc_q;
              if (c_end) begin
                fin = 1'b1; emit = 1'b1;
                res_act_d = sens_q ? smcd_pkg::ACT_TURN : smcd_pkg::ACT_SENSOR;
              end else begin
                pst_d = P_TR_TL;
              end
            end
          end
          P_TR_TL: begin
            if (c_end) begin
              fin = 1'b1; emit = 1'b1;
              res_act_d = sens_q ? smcd_pkg::ACT_TURN : smcd_pkg::ACT_SENSOR;
            end else if (!c_blank) begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_FMT;
            end
          end
          P_Y_BL: begin
            if (c == smcd_pkg::CH_ZERO) begin
              if (busy_q) begin
                fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_BUSY;
              end else begin
                pst_d = P_Y_Z;
              end
            end else if (c_end) begin
              fin = 1'b1; emit = 1'b1;
              res_act_d = sens_q ? smcd_pkg::ACT_READ : smcd_pkg::ACT_SENSOR;
            end else if (!c_blank) begin
              fin = 1'b1;
            end
          end
          P_Y_Z: begin
            if (c_end) begin
              fin = 1'b1; emit = 1'b1; res_act_d = smcd_pkg::ACT_ZERO;
            end else if (!c_blank) begin
              fin = 1'b1;
            end
          end
          P_MSP: begin
            if (c_end) begin
              mfin = 1'b1;
            end else if (c_digit && {6'd0, dig} <= max_spd_q) begin
              acc_d = {6'd0, dig};
              pst_d = P_MSN;
            end else if (!c_blank) begin
              fin = 1'b1;
            end
          end
          P_MSN: begin
            if (c_digit) begin
              if (nx10 > {4'd0, max_spd_q}) begin
                fin = 1'b1;
              end else begin
                acc_d = nx10[9:0];
              end
            end else begin
              spd_d = acc_q;
              if (c_end) begin
                mfin = 1'b1;
              end else if (c_blank) begin
                pst_d = P_MPB;
              end else begin
                fin = 1'b1;
              end
            end
          end
          P_MPB: begin
            if (c_end) begin
              mfin = 1'b1;
            end else if (c_digit) begin
              acc_d = {6'd0, dig};
              pst_d = P_MPN;
            end else if (!c_blank) begin
              fin = 1'b1;
            end
          end
          P_MPN: begin
            if (c_digit) begin
              if (nx10 > {7'd0, smcd_pkg::PCT_LIMIT}) begin
                fin = 1'b1;
              end else begin
                acc_d = nx10[9:0];
              end
            end else begin
              inr_d = acc_q[6:0];
              pct_d = 1'b1;
              if (c_end) begin
                mfin = 1'b1;
              end else if (c_blank) begin
                pst_d = P_MTAIL;
              end else begin
                fin = 1'b1;
              end
            end
          end
          default: begin
            if (c_end) begin
              mfin = 1'b1;
            end else if (!c_blank) begin
              fin = 1'b1;
            end
          end
        endcase

        // motion line complete: a percent needs an arc letter
        if (mfin) begin
          fin = 1'b1;
          if (!(pct_d && side_q == smcd_pkg::SIDE_NONE)) begin
            mok       = 1'b1;
            emit      = 1'b1;
            res_act_d = smcd_pkg::ACT_MOTION;
            case (cmd_q)
              CMD_L:   res_mot_d = smcd_pkg::MOT_PIV_L;
              CMD_R:   res_mot_d = smcd_pkg::MOT_PIV_R;
              CMD_F:   res_mot_d = smcd_pkg::MOT_FWD + {1'b0, side_q};
              default: res_mot_d = smcd_pkg::MOT_BACK + {1'b0, side_q};
            endcase
          end
        end
        if (fin) begin
          ph_d = emit ? PH_EMIT : PH_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          ph_d = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      pst_q       <= P_LEAD;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      max_spd_q   <= smcd_pkg::MAX_SPEED_RST;
      turn_rpm_q  <= smcd_pkg::TURN_RPM_RST;
      start_spd_q <= smcd_pkg::START_SPEED_RST;
      start_inr_q <= smcd_pkg::START_INNER_RST;
      held_spd_q  <= smcd_pkg::START_SPEED_RST;
      held_inr_q  <= smcd_pkg::START_INNER_RST;
    end else begin
      ph_q  <= ph_d;
      pst_q <= pst_d;

      if (in_acc) begin
        if (is_term || cnt_q >= AW'(LINE_BYTES - 1)) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + AW'(1);
        end
      end

      if (cfg_wr) begin
        case (paddr[3:2])
          smcd_pkg::REG_MAX_SPEED:   max_spd_q  <= pwdata[9:0];
          smcd_pkg::REG_TURN_RPM:    turn_rpm_q <= pwdata[9:0];
          smcd_pkg::REG_START_SPEED: begin
            start_spd_q <= pwdata[9:0];
            held_spd_q  <= pwdata[9:0];
          end
          default: begin
            start_inr_q <= (pwdata[6:0] > smcd_pkg::PCT_LIMIT) ?
                           smcd_pkg::PCT_LIMIT : pwdata[6:0];
            held_inr_q  <= (pwdata[6:0] > smcd_pkg::PCT_LIMIT) ?
                           smcd_pkg::PCT_LIMIT : pwdata[6:0];
          end
        endcase
      end else if (mok) begin
        held_spd_q <= spd_d;
        held_inr_q <= inr_d;
      end

      if (ph_q == PH_EMIT && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // parser payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    side_q    <= side_d;
    acc_q     <= acc_d;
    ang_q     <= ang_d;
    spd_q     <= spd_d;
    inr_q     <= inr_d;
    trpm_q    <= trpm_d;
    pct_q     <= pct_d;
    idx_q     <= idx_d;
    res_act_q <= res_act_d;
    res_mot_q <= res_mot_d;
    if (in_acc && is_term) begin
      len_q  <= cnt_q;
      sens_q <= sensor_ready_i;
      busy_q <= turn_active_i;
    end
    // fields that do not belong to the action read as zero
    if (ph_q == PH_EMIT && out_free) begin
      action_o        <= res_act_q;
      motion_o        <= (res_act_q == smcd_pkg::ACT_MOTION) ? res_mot_q : 3'd0;
      speed_rpm_o     <= (res_act_q == smcd_pkg::ACT_MOTION) ? spd_q : 10'd0;
      inner_percent_o <= (res_act_q == smcd_pkg::ACT_MOTION) ? inr_q : 7'd0;
      turn_left_o     <= (res_act_q == smcd_pkg::ACT_TURN) && (side_q == smcd_pkg::SIDE_L);
      angle_tenths_o  <= (res_act_q == smcd_pkg::ACT_TURN) ? ang_q : 12'd0;
      turn_max_rpm_o  <= (res_act_q == smcd_pkg::ACT_TURN) ? trpm_q : 10'd0;
    end
  end

endmodule

@@ rtl/core/smcd_checker.sv @@
`timescale 1ns / 1ps
// port level checker for the serial motion command decoder, with its bind
// depends on smcd_pkg
module smcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  action_o,
  input logic [2:0]  motion_o,
  input logic [9:0]  speed_rpm_o,
  input logic [6:0]  inner_percent_o,
  input logic        turn_left_o,
  input logic [11:0] angle_tenths_o,
  input logic [9:0]  turn_max_rpm_o
);

  // stalled result word holds: valid, action, motion and angle stay stable
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) &&
    $stable(motion_o) && $stable(angle_tenths_o))
    else $error("stalled result changed");

  a_mot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != smcd_pkg::ACT_MOTION |->
    motion_o == 3'd0 && speed_rpm_o == 10'd0 && inner_percent_o == 7'd0)
    else $error("motion fields set on a non-motion result");

  a_turn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != smcd_pkg::ACT_TURN |->
    !turn_left_o && angle_tenths_o == 12'd0 && turn_max_rpm_o == 10'd0)
    else $error("turn fields set on a non-turn result");

  a_turn_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == smcd_pkg::ACT_TURN |->
    angle_tenths_o != 12'd0 && angle_tenths_o <= smcd_pkg::TENTHS_LIMIT &&
    turn_max_rpm_o != 10'd0)
    else $error("turn angle or rpm out of range");

  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == smcd_pkg::ACT_MOTION |->
    inner_percent_o <= smcd_pkg::PCT_LIMIT)
    else $error("inner percent above limit");

endmodule

bind serial_motion_command_decoder smcd_checker u_smcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_o        (action_o),
  .motion_o        (motion_o),
  .speed_rpm_o     (speed_rpm_o),
  .inner_percent_o (inner_percent_o),
  .turn_left_o     (turn_left_o),
  .angle_tenths_o  (angle_tenths_o),
  .turn_max_rpm_o  (turn_max_rpm_o)
);
